/* design/floor_texel_from_ray_top_defines.svh */
// Assertion macros for the floor texel pipeline.
`ifndef FLOOR_TEXEL_FROM_RAY_TOP_DEFINES_SVH
`define FLOOR_TEXEL_FROM_RAY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FT_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("floor texel check failed");
`define FT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("floor texel implication failed");
`else
`define FT_ASSERT_HOLD(label, cond)
`define FT_ASSERT_IMP(label, ante, cons)
`endif
`endif

/* design/ftr_pkg.sv */
package ftr_pkg;
  localparam int CFG_W = 13;
  localparam int ROW_W = 12;
  localparam int TEX_W = 12;
  localparam int WFRAC_W = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SCREEN_HEIGHT = 2'd0,
    REG_X_LIMIT       = 2'd1,
    REG_TEX_WIDTH     = 2'd2,
    REG_TEX_HEIGHT    = 2'd3
  } reg_idx_t;

  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] X_LIMIT_RST       = 13'd640;
  localparam logic [CFG_W-1:0] TEX_WIDTH_RST     = 13'd64;
  localparam logic [CFG_W-1:0] TEX_HEIGHT_RST    = 13'd64;
endpackage

/* design/floor_texel_from_ray_top.sv */
// Floor texel address generator, one floor pixel per transaction.
// Input channel (in_valid/in_ready): ray wall hit, viewer position and
// screen row. Output channel (out_valid/out_ready): texel_u, texel_v and
// in_bounds; texel_u/texel_v are zero when in_bounds is low.
// Configuration: APB port, screen_height at 0x0, x_limit at 0x4,
// tex_width at 0x8, tex_height at 0xC; write only while idle.
// Throughput: one transaction per clock while out_ready does not stall it.
// The depth is set by the weight divider, one quotient bit per stage
// (FRAC_BITS + 1 stages), plus input, edge point, divider setup, weight
// clamp, multiply, blend and texel stages.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults 480, 640, 64, 64.
// When out_ready is low with a result waiting, the whole pipeline holds;
// in_ready drops and no data is lost or repeated.
`include "floor_texel_from_ray_top_defines.svh"
module floor_texel_from_ray_top #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ftr_pkg::ADDR_W-1:0] paddr,
  input  logic [ftr_pkg::DATA_W-1:0] pwdata,
  output logic [ftr_pkg::DATA_W-1:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic hit_side,
  input  logic signed [1:0] dir_x_sign,
  input  logic signed [1:0] dir_y_sign,
  input  logic [INT_BITS+FRAC_BITS-1:0] cell_x,
  input  logic [INT_BITS+FRAC_BITS-1:0] cell_y,
  input  logic [ftr_pkg::WFRAC_W-1:0] wall_frac,
  input  logic [INT_BITS+FRAC_BITS-1:0] ray_dist,
  input  logic [ftr_pkg::ROW_W-1:0] row_y,
  input  logic [INT_BITS+FRAC_BITS-1:0] viewer_x,
  input  logic [INT_BITS+FRAC_BITS-1:0] viewer_y,
  output logic out_valid,
  input  logic out_ready,
  output logic [ftr_pkg::TEX_W-1:0] texel_u,
  output logic [ftr_pkg::TEX_W-1:0] texel_v,
  output logic in_bounds
);
  import ftr_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int P = INT_BITS + FRAC_BITS;
  localparam int D = F + 1;
  localparam int DEN_W = CFG_W + P;
  localparam int REM_W = DEN_W + F + 2;
  localparam int FX_W = F + INT_BITS + 3;
  localparam logic [F:0] ONE_W = (F+1)'(1) << F;

  typedef struct packed {
    logic [P:0] ex;
    logic [P:0] ey;
    logic [P-1:0] vx;
    logic [P-1:0] vy;
  } pos_t;

  logic [CFG_W-1:0] screen_height, x_limit, tex_width, tex_height;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= SCREEN_HEIGHT_RST;
      x_limit <= X_LIMIT_RST;
      tex_width <= TEX_WIDTH_RST;
      tex_height <= TEX_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCREEN_HEIGHT: screen_height <= pwdata[CFG_W-1:0];
        REG_X_LIMIT: x_limit <= pwdata[CFG_W-1:0];
        REG_TEX_WIDTH: tex_width <= pwdata[CFG_W-1:0];
        REG_TEX_HEIGHT: tex_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_height);
      REG_X_LIMIT: prdata = DATA_W'(x_limit);
      REG_TEX_WIDTH: prdata = DATA_W'(tex_width);
      REG_TEX_HEIGHT: prdata = DATA_W'(tex_height);
      default: prdata = '0;
    endcase
  end

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: input register
  logic v1;
  logic side1, xpos1, xneg1, ypos1;
  logic [P-1:0] cx1, cy1, dist1, vx1, vy1;
  logic [WFRAC_W-1:0] wf1;
  logic [ROW_W-1:0] row1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      side1 <= hit_side;
      xpos1 <= (dir_x_sign == 2'sb01);
      xneg1 <= dir_x_sign[1];
      ypos1 <= (dir_y_sign == 2'sb01);
      cx1 <= cell_x;
      cy1 <= cell_y;
      wf1 <= wall_frac;
      dist1 <= ray_dist;
      row1 <= row_y;
      vx1 <= viewer_x;
      vy1 <= viewer_y;
    end
  end

  // stage 2: edge point, denominator product
  logic [F-1:0] frac_al;
  generate
    if (F >= WFRAC_W) begin : g_frac_up
      assign frac_al = F'(wf1) << (F - WFRAC_W);
    end else begin : g_frac_dn
      assign frac_al = F'(wf1 >> (WFRAC_W - F));
    end
  endgenerate

  logic [P:0] cx_e, cy_e, fr_e, one_e;
  logic [CFG_W-1:0] twice1, dsub1;
  pos_t pos_c;
  assign cx_e = (P+1)'(cx1);
  assign cy_e = (P+1)'(cy1);
  assign fr_e = (P+1)'(frac_al);
  assign one_e = (P+1)'(1) << F;
  assign twice1 = {row1, 1'b0};
  assign dsub1 = twice1 - screen_height;

  always_comb begin
    pos_c.vx = vx1;
    pos_c.vy = vy1;
    if (!side1 && xpos1) begin
      pos_c.ex = cx_e;
      pos_c.ey = cy_e + fr_e;
    end else if (!side1 && xneg1) begin
      pos_c.ex = cx_e + one_e;
      pos_c.ey = cy_e + fr_e;
    end else if (side1 && ypos1) begin
      pos_c.ex = cx_e + fr_e;
      pos_c.ey = cy_e;
    end else begin
      pos_c.ex = cx_e + fr_e;
      pos_c.ey = cy_e + one_e;
    end
  end

  logic v2, force2;
  pos_t pos2;
  logic [DEN_W-1:0] den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      pos2 <= pos_c;
      den2 <= DEN_W'(dsub1) * DEN_W'(dist1);
      force2 <= (twice1 <= screen_height);
    end
  end

  // stage 3 and divider: one quotient bit per stage
  logic dv_vld [0:D];
  logic dv_sat [0:D];
  pos_t dv_pos [0:D];
  logic [DEN_W-1:0] dv_den [0:D];
  logic [REM_W-1:0] dv_rem [0:D];
  logic [F:0] dv_q [0:D];
  logic [REM_W-1:0] num2;
  assign num2 = REM_W'(screen_height) << (2 * F);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= v2;
      dv_pos[0] <= pos2;
      dv_den[0] <= den2;
      dv_rem[0] <= num2;
      dv_q[0] <= '0;
      dv_sat[0] <= force2 || (num2 >= (REM_W'(den2) << (F + 1)));
    end
  end

  generate
    for (genvar k = 0; k < D; k++) begin : g_div
      logic [REM_W-1:0] sub;
      logic take;
      assign sub = REM_W'(dv_den[k]) << (F - k);
      assign take = dv_rem[k] >= sub;
      always_ff @(posedge clk) begin
        if (rst) begin
          dv_vld[k+1] <= 1'b0;
        end else if (en) begin
          dv_vld[k+1] <= dv_vld[k];
          dv_pos[k+1] <= dv_pos[k];
          dv_den[k+1] <= dv_den[k];
          dv_sat[k+1] <= dv_sat[k];
          dv_rem[k+1] <= take ? dv_rem[k] - sub : dv_rem[k];
          dv_q[k+1] <= {dv_q[k][F-1:0], take};
        end
      end
    end
  endgenerate

  // weight clamp
  logic vw;
  pos_t posw;
  logic [F:0] w;
  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= 1'b0;
    end else if (en) begin
      vw <= dv_vld[D];
      posw <= dv_pos[D];
      w <= (dv_sat[D] || dv_q[D] > ONE_W) ? ONE_W : dv_q[D];
    end
  end

  // blend products
  logic [F:0] iw;
  assign iw = ONE_W - w;
  localparam int HA_W = F + INT_BITS + 2;
  localparam int HB_W = F + INT_BITS + 1;
  localparam int LO_W = 2 * F + 1;
  logic vm;
  logic [HA_W-1:0] hax, hay;
  logic [HB_W-1:0] hbx, hby;
  logic [LO_W-1:0] lax, lay, lbx, lby;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vw;
      hax <= HA_W'(w) * HA_W'(posw.ex[P:F]);
      hay <= HA_W'(w) * HA_W'(posw.ey[P:F]);
      hbx <= HB_W'(iw) * HB_W'(posw.vx[P-1:F]);
      hby <= HB_W'(iw) * HB_W'(posw.vy[P-1:F]);
      lax <= LO_W'(w) * LO_W'(posw.ex[F-1:0]);
      lay <= LO_W'(w) * LO_W'(posw.ey[F-1:0]);
      lbx <= LO_W'(iw) * LO_W'(posw.vx[F-1:0]);
      lby <= LO_W'(iw) * LO_W'(posw.vy[F-1:0]);
    end
  end

  // blend sums and bounds
  logic [LO_W:0] lsx, lsy;
  logic [FX_W-1:0] fx_c, fy_c;
  assign lsx = (LO_W+1)'(lax) + (LO_W+1)'(lbx);
  assign lsy = (LO_W+1)'(lay) + (LO_W+1)'(lby);
  assign fx_c = FX_W'(hax) + FX_W'(hbx) + FX_W'(lsx >> F);
  assign fy_c = FX_W'(hay) + FX_W'(hby) + FX_W'(lsy >> F);

  logic vs, inb_s;
  logic [F-1:0] frx, fry;
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (en) begin
      vs <= vm;
      frx <= fx_c[F-1:0];
      fry <= fy_c[F-1:0];
      inb_s <= ((FX_W+CFG_W)'(fx_c) < ((FX_W+CFG_W)'(x_limit) << F)) &&
               ((FX_W+CFG_W)'(fy_c) < ((FX_W+CFG_W)'(screen_height) << F));
    end
  end

  // texel scale, output register
  logic [F+CFG_W-1:0] tu, tv;
  assign tu = (F+CFG_W)'(frx) * (F+CFG_W)'(tex_width);
  assign tv = (F+CFG_W)'(fry) * (F+CFG_W)'(tex_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs;
      in_bounds <= inb_s;
      texel_u <= inb_s ? tu[F+TEX_W-1:F] : '0;
      texel_v <= inb_s ? tv[F+TEX_W-1:F] : '0;
    end
  end

  `FT_ASSERT_IMP(a_oob_zero, out_valid && !in_bounds, texel_u == '0 && texel_v == '0)
  `FT_ASSERT_IMP(a_u_range, out_valid && in_bounds && tex_width != '0,
                 CFG_W'(texel_u) < tex_width)
  `FT_ASSERT_IMP(a_v_range, out_valid && in_bounds && tex_height != '0,
                 CFG_W'(texel_v) < tex_height)
  `FT_ASSERT_HOLD(a_ready, in_ready == (!out_valid || out_ready))
endmodule

/* bench/floor_texel_checker.sv */
`timescale 1ns / 1ps
module floor_texel_checker #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ftr_pkg::ADDR_W-1:0] paddr,
  input  logic [ftr_pkg::DATA_W-1:0] pwdata,
  input  logic pready,
  input  logic in_valid,
  input  logic in_ready,
  input  logic hit_side,
  input  logic signed [1:0] dir_x_sign,
  input  logic signed [1:0] dir_y_sign,
  input  logic [INT_BITS+FRAC_BITS-1:0] cell_x,
  input  logic [INT_BITS+FRAC_BITS-1:0] cell_y,
  input  logic [ftr_pkg::WFRAC_W-1:0] wall_frac,
  input  logic [INT_BITS+FRAC_BITS-1:0] ray_dist,
  input  logic [ftr_pkg::ROW_W-1:0] row_y,
  input  logic [INT_BITS+FRAC_BITS-1:0] viewer_x,
  input  logic [INT_BITS+FRAC_BITS-1:0] viewer_y,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [ftr_pkg::TEX_W-1:0] texel_u,
  input  logic [ftr_pkg::TEX_W-1:0] texel_v,
  input  logic in_bounds,
  output int errors,
  output int pending,
  output int texels_seen,
  output int oob_seen
);
  import ftr_pkg::*;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] FMASK = ONE - 1;

  typedef struct packed {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
    logic ib;
  } texel_t;

  logic [CFG_W-1:0] scr_h, x_lim, tex_w, tex_h;
  texel_t texel_q[$];

  function automatic logic [63:0] mix_toward_viewer(logic [63:0] w, logic [63:0] a,
                                                    logic [63:0] b);
    logic [63:0] iw, hi, lo;
    iw = ONE - w;
    hi = w * (a >> FRAC_BITS) + iw * (b >> FRAC_BITS);
    lo = w * (a & FMASK) + iw * (b & FMASK);
    return hi + (lo >> FRAC_BITS);
  endfunction

  function automatic logic [TEX_W-1:0] tex_coord(logic [63:0] pos, logic [CFG_W-1:0] size);
    logic [63:0] s;
    s = (size == 0) ? 64'd1 : 64'(size);
    return TEX_W'(((pos * s) >> FRAC_BITS) % s);
  endfunction

  function automatic texel_t predict_texel();
    logic [63:0] frac, ex, ey, w, fx, fy, twice, d, q;
    texel_t t;
    frac = (FRAC_BITS >= 16) ? (64'(wall_frac) << (FRAC_BITS - 16))
                             : (64'(wall_frac) >> (16 - FRAC_BITS));
    if (!hit_side && dir_x_sign == 2'sd1) begin
      ex = cell_x;
      ey = cell_y + frac;
    end else if (!hit_side && dir_x_sign[1]) begin
      ex = cell_x + ONE;
      ey = cell_y + frac;
    end else if (hit_side && dir_y_sign == 2'sd1) begin
      ex = cell_x + frac;
      ey = cell_y;
    end else begin
      ex = cell_x + frac;
      ey = cell_y + ONE;
    end
    twice = 64'(row_y) * 2;
    if (twice <= scr_h || ray_dist == 0) begin
      w = ONE;
    end else begin
      d = twice - scr_h;
      q = (64'(scr_h) << (2 * FRAC_BITS)) / (d * ray_dist);
      w = (q > ONE) ? ONE : q;
    end
    fx = mix_toward_viewer(w, ex, viewer_x);
    fy = mix_toward_viewer(w, ey, viewer_y);
    if (fx < (64'(x_lim) << FRAC_BITS) && fy < (64'(scr_h) << FRAC_BITS)) begin
      t.u = tex_coord(fx, tex_w);
      t.v = tex_coord(fy, tex_h);
      t.ib = 1'b1;
    end else begin
      t = '0;
    end
    return t;
  endfunction

  assign pending = texel_q.size();

  always @(posedge clk) begin
    texel_t exp_t;
    if (rst) begin
      scr_h <= SCREEN_HEIGHT_RST;
      x_lim <= X_LIMIT_RST;
      tex_w <= TEX_WIDTH_RST;
      tex_h <= TEX_HEIGHT_RST;
      texel_q.delete();
      errors <= 0;
      texels_seen <= 0;
      oob_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SCREEN_HEIGHT: scr_h <= pwdata[CFG_W-1:0];
          REG_X_LIMIT:       x_lim <= pwdata[CFG_W-1:0];
          REG_TEX_WIDTH:     tex_w <= pwdata[CFG_W-1:0];
          REG_TEX_HEIGHT:    tex_h <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) texel_q.push_back(predict_texel());
      if (out_valid && out_ready) begin
        if (texel_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected output transaction u=%0d v=%0d ib=%0b",
                                    texel_u, texel_v, in_bounds);
        end else begin
          exp_t = texel_q.pop_front();
          texels_seen <= texels_seen + 1;
          if (!in_bounds) oob_seen <= oob_seen + 1;
          if (exp_t.u !== texel_u || exp_t.v !== texel_v || exp_t.ib !== in_bounds) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp u=%0d v=%0d ib=%0b, got u=%0d v=%0d ib=%0b",
                       exp_t.u, exp_t.v, exp_t.ib, texel_u, texel_v, in_bounds);
          end
        end
      end
    end
  end
endmodule

/* bench/floor_texel_from_ray_top_tb.sv */
`timescale 1ns / 1ps
module floor_texel_from_ray_top_tb;
  import ftr_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS = 10;
  localparam int P = INT_BITS + FRAC_BITS;
  localparam int STALL_LIMIT = 5000;
  localparam int LATENCY = FRAC_BITS + 8;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic hit_side;
  logic signed [1:0] dir_x_sign, dir_y_sign;
  logic [P-1:0] cell_x, cell_y, ray_dist, viewer_x, viewer_y;
  logic [WFRAC_W-1:0] wall_frac;
  logic [ROW_W-1:0] row_y;
  logic [TEX_W-1:0] texel_u, texel_v;
  logic in_bounds;
  int errors, pending, texels_seen, oob_seen;
  int tx_idle_pct, rx_idle_pct;
  int quiet_cycles;
  int cur_h, cur_xl;

  floor_texel_from_ray_top dut (.*);

  floor_texel_checker chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .hit_side, .dir_x_sign, .dir_y_sign, .cell_x, .cell_y,
    .wall_frac, .ray_dist, .row_y, .viewer_x, .viewer_y,
    .out_valid, .out_ready, .texel_u, .texel_v, .in_bounds,
    .errors, .pending, .texels_seen, .oob_seen
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic set_view(int h, int xl, int tw, int th);
    drain_pipe();
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_X_LIMIT, xl);
    write_reg(REG_TEX_WIDTH, tw);
    write_reg(REG_TEX_HEIGHT, th);
    cur_h = h;
    cur_xl = xl;
  endtask

  task automatic send_ray(logic side, logic [1:0] sx, logic [1:0] sy, logic [P-1:0] cx,
                          logic [P-1:0] cy, logic [15:0] wf, logic [P-1:0] rdist,
                          logic [11:0] row, logic [P-1:0] vx, logic [P-1:0] vy);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    hit_side = side; dir_x_sign = sx; dir_y_sign = sy;
    cell_x = cx; cell_y = cy; wall_frac = wf; ray_dist = rdist;
    row_y = row; viewer_x = vx; viewer_y = vy;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [P-1:0] rand_pos(int lim);
    if ($urandom_range(9) == 0) return P'($urandom);
    return P'(($urandom_range(lim) << FRAC_BITS) | $urandom_range(16'hFFFF));
  endfunction

  function automatic logic [1:0] rand_sign();
    case ($urandom_range(7))
      0, 1, 2: return 2'b01;
      3, 4, 5: return 2'b11;
      6: return 2'b00;
      default: return 2'b10;
    endcase
  endfunction

  task automatic random_rays(int n);
    int lim;
    logic [P-1:0] rdist;
    logic [11:0] row;
    repeat (n) begin
      lim = (cur_h < cur_xl ? cur_h : cur_xl);
      lim = (lim > 1023) ? 1023 : lim;
      case ($urandom_range(3))
        0: rdist = P'($urandom_range(1, 16'hFFFF));
        1, 2: rdist = P'($urandom_range(1, 32 << FRAC_BITS));
        default: rdist = P'($urandom);
      endcase
      if ($urandom_range(9) == 0) row = 12'($urandom);
      else row = 12'($urandom_range(cur_h > 4095 ? 4095 : cur_h));
      send_ray($urandom_range(1), rand_sign(), rand_sign(), rand_pos(lim), rand_pos(lim),
               16'($urandom), rdist, row, rand_pos(lim), rand_pos(lim));
    end
  endtask

  initial begin
    int ph;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; hit_side = 0; dir_x_sign = 0; dir_y_sign = 0;
    cell_x = '0; cell_y = '0; wall_frac = '0; ray_dist = '0; row_y = '0;
    viewer_x = '0; viewer_y = '0;
    tx_idle_pct = 25; rx_idle_pct = 86;
    cur_h = 480; cur_xl = 640;
    out_ready = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // edge cases at reset defaults
    send_ray(0, 2'b01, 2'b00, 26'd10 << 16, 26'd20 << 16, 16'h8000, 26'd3 << 16, 12'd300,
             26'd12 << 16, 26'd22 << 16);
    send_ray(0, 2'b11, 2'b01, 26'd10 << 16, 26'd20 << 16, 16'hFFFF, 26'd1, 12'd481,
             26'd5 << 16, 26'd5 << 16);
    send_ray(1, 2'b01, 2'b01, 26'd30 << 16, 26'd40 << 16, 16'h0000, 26'h3FFFFFF, 12'd479,
             26'd30 << 16, 26'd50 << 16);
    send_ray(1, 2'b00, 2'b11, 26'd30 << 16, 26'd40 << 16, 16'h1234, 26'd2 << 16, 12'd240,
             26'd1 << 16, 26'd1 << 16);
    send_ray(0, 2'b10, 2'b10, 26'h3FFFFFF, 26'h3FFFFFF, 16'hFFFF, 26'd0, 12'hFFF,
             26'h3FFFFFF, 26'h3FFFFFF);
    send_ray(1, 2'b10, 2'b00, 26'd0, 26'd0, 16'd0, 26'd1 << 16, 12'd0, 26'd0, 26'd0);
    send_ray(0, 2'b00, 2'b11, 26'd639 << 16, 26'd479 << 16, 16'hFFFF, 26'd1 << 16, 12'd400,
             26'd639 << 16, 26'd479 << 16);
    send_ray(1, 2'b11, 2'b01, 26'd100 << 16, 26'd100 << 16, 16'h4000, 26'd1 << 14,
             12'hFFF, 26'd200 << 16, 26'd200 << 16);
    set_view(2, 1, 1, 1);
    send_ray(0, 2'b01, 2'b01, 26'd0, 26'd0, 16'h8000, 26'd1 << 16, 12'd2, 26'd0, 26'd0);
    send_ray(1, 2'b11, 2'b11, 26'd0, 26'd0, 16'hFFFF, 26'd1, 12'd1, 26'h8000, 26'h8000);
    send_ray(0, 2'b11, 2'b00, 26'd0, 26'd0, 16'd0, 26'h3FFFFFF, 12'hFFF, 26'hFFFF, 26'hFFFF);
    set_view(4096, 4096, 4096, 4096);
    send_ray(0, 2'b01, 2'b11, 26'h3FFFFFF, 26'h3FFFFFF, 16'hFFFF, 26'd1, 12'hFFF,
             26'h3FFFFFF, 26'h3FFFFFF);
    send_ray(1, 2'b01, 2'b01, 26'd1000 << 16, 26'd777 << 16, 16'h0F0F, 26'd1 << 16,
             12'd3000, 26'd3 << 16, 26'd9 << 16);
    send_ray(1, 2'b00, 2'b00, 26'd5, 26'd7, 16'hAAAA, 26'd8 << 16, 12'd2048,
             26'd1023 << 16, 26'd1023 << 16);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_view(480, 640, 64, 64);
        1: set_view($urandom_range(2, 4096), $urandom_range(1, 4096),
                    $urandom_range(1, 4096), $urandom_range(1, 4096));
        2: set_view(200, 320, 7, 3);
        3: set_view(4096, 4096, 4096, 1);
        4: set_view(2, 4096, 1, 4096);
        default: set_view($urandom_range(2, 1024), $urandom_range(1, 1024),
                          $urandom_range(1, 128), $urandom_range(1, 128));
      endcase
      if (ph == 2) begin
        tx_idle_pct = 86; rx_idle_pct = 25;
      end else if (ph == 4) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      random_rays(200);
    end
    @(negedge clk);
    in_valid = 0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
    $display("checked %0d texel results (%0d out of bounds) over 9 register settings",
             texels_seen, oob_seen);
    $display("including horizon, zero-distance and extreme-coordinate rays");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/ftr_pkg.sv
design/floor_texel_from_ray_top.sv
bench/floor_texel_checker.sv
bench/floor_texel_from_ray_top_tb.sv
